### hdl/ptt_pkg.sv
// Shared constants and types for the pressure trend tracker.
package ptt_pkg;

	localparam logic [39:0] EPOCH_MIN = 40'd1600000000;
	localparam logic [16:0] PRESS_MIN = 17'd30000;
	localparam logic [16:0] PRESS_MAX = 17'd120000;

	localparam logic [16:0] WINDOW_RESET = 17'd10800;
	localparam logic [16:0] SLOW_RESET   = 17'd50;
	localparam logic [16:0] FAST_RESET   = 17'd200;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_SLOW   = 2'd1;
	localparam logic [1:0] REG_FAST   = 2'd2;

	localparam logic [2:0] CLASS_STEADY       = 3'd0;
	localparam logic [2:0] CLASS_RISING       = 3'd1;
	localparam logic [2:0] CLASS_RISING_FAST  = 3'd2;
	localparam logic [2:0] CLASS_FALLING      = 3'd3;
	localparam logic [2:0] CLASS_FALLING_FAST = 3'd4;

	// Search token that walks down the row of history cells.
	typedef struct packed {
		logic        valid;
		logic        hit;
		logic [16:0] best_p;
	} token_t;

endpackage

### hdl/ptt_cell.sv
// One history cell: holds a stored sample and tests the passing search token.
module ptt_cell #(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  logic [39:0]       t_in,
	input  logic [16:0]       p_in,
	input  ptt_pkg::token_t   tok_in,
	input  logic [CW-1:0]     fill,
	input  logic [39:0]       limit,
	output logic [39:0]       t_out,
	output logic [16:0]       p_out,
	output ptt_pkg::token_t   tok_out
);

	logic [39:0]     t_q;
	logic [16:0]     p_q;
	ptt_pkg::token_t tok_q;
	logic            take;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			t_q <= t_in;
			p_q <= p_in;
		end
	end

	// Cells are ordered newest first, so the first qualifying cell is the youngest one.
	assign take = tok_in.valid && !tok_in.hit && (fill > CW'(IDX)) && (t_q <= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid  <= tok_in.valid;
			tok_q.hit    <= tok_in.hit | take;
			tok_q.best_p <= take ? p_q : tok_in.best_p;
		end
	end

	assign t_out   = t_q;
	assign p_out   = p_q;
	assign tok_out = tok_q;

endmodule

### hdl/pressure_trend_tracker.sv
// Pressure trend tracker: sample checks, history row and trend classification.
//
// Input beats carry sample_epoch and pressure on in_valid/in_stall. Each input beat
// yields exactly one output beat on out_valid/out_stall with accepted,
// found_reference, trend_valid, delta and trend_class.
// A sample that passes the checks is pushed into the head of a row of
// HISTORY_DEPTH cells (newest first). A search token then walks the row one
// cell per cycle and picks the newest sample at least window_seconds old.
// An accepted sample reaches its output beat once the search token has walked
// the whole cell row; a rejected one goes straight to the finish state. Only
// one sample is in work at a time.
// The block takes a new input beat while the previous output beat is still
// stalled; the finished result of that sample waits until the output frees.
// Configuration writes (cfg_index 0 window, 1 slow, 2 fast threshold) are
// always taken; index 3 is ignored.
// Reset clears the fill count, last epoch and held trend, and restores the
// register defaults. Stored samples need no clearing.
module pressure_trend_tracker #(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [39:0] sample_epoch,
	input  logic [16:0] pressure,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic        found_reference,
	output logic        trend_valid,
	output logic signed [17:0] delta,
	output logic [2:0]  trend_class
);

	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]  state_q;
	logic [16:0] window_q, slow_q, fast_q;
	logic [39:0] last_epoch_q, limit_q;
	logic [16:0] p_q;
	logic [CW-1:0] fill_q;
	logic        start_q;
	logic        acc_q, found_q;
	logic        have_q;
	logic signed [17:0] held_delta_q;
	logic [2:0]  held_class_q;
	logic        out_valid_q, out_acc_q, out_found_q, out_have_q;
	logic signed [17:0] out_delta_q;
	logic [2:0]  out_class_q;

	logic        in_fire, ok, shift_en, out_free;
	logic signed [18:0] d19, slow19, fast19;
	logic [2:0]  cls;

	logic [39:0]     t_w   [HISTORY_DEPTH];
	logic [16:0]     p_w   [HISTORY_DEPTH];
	ptt_pkg::token_t tok_w [HISTORY_DEPTH];
	ptt_pkg::token_t tok_head;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign ok = (sample_epoch >= ptt_pkg::EPOCH_MIN) && (sample_epoch > last_epoch_q) &&
		(pressure >= ptt_pkg::PRESS_MIN) && (pressure <= ptt_pkg::PRESS_MAX);
	assign shift_en = in_fire && ok;
	assign out_free = !out_valid_q || !out_stall;

	assign tok_head.valid  = start_q;
	assign tok_head.hit    = 1'b0;
	assign tok_head.best_p = '0;

	for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_head
			ptt_cell #(.IDX(k), .CW(CW)) u_cell (
				.clk(clk), .arst_n(arst_n), .shift_en(shift_en),
				.t_in(sample_epoch), .p_in(pressure), .tok_in(tok_head),
				.fill(fill_q), .limit(limit_q),
				.t_out(t_w[k]), .p_out(p_w[k]), .tok_out(tok_w[k])
			);
		end else begin : g_body
			ptt_cell #(.IDX(k), .CW(CW)) u_cell (
				.clk(clk), .arst_n(arst_n), .shift_en(shift_en),
				.t_in(t_w[k-1]), .p_in(p_w[k-1]), .tok_in(tok_w[k-1]),
				.fill(fill_q), .limit(limit_q),
				.t_out(t_w[k]), .p_out(p_w[k]), .tok_out(tok_w[k])
			);
		end
	end

	// Difference and class of the current sample against the found reference.
	assign d19    = 19'(signed'({2'b00, p_q})) -
		19'(signed'({2'b00, tok_w[HISTORY_DEPTH-1].best_p}));
	assign slow19 = signed'({2'b00, slow_q});
	assign fast19 = signed'({2'b00, fast_q});

	always_comb begin
		if (d19 <= -fast19) begin
			cls = ptt_pkg::CLASS_FALLING_FAST;
		end else if (d19 <= -slow19) begin
			cls = ptt_pkg::CLASS_FALLING;
		end else if (d19 >= fast19) begin
			cls = ptt_pkg::CLASS_RISING_FAST;
		end else if (d19 >= slow19) begin
			cls = ptt_pkg::CLASS_RISING;
		end else begin
			cls = ptt_pkg::CLASS_STEADY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= ptt_pkg::WINDOW_RESET;
			slow_q   <= ptt_pkg::SLOW_RESET;
			fast_q   <= ptt_pkg::FAST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ptt_pkg::REG_WINDOW: window_q <= cfg_data;
				ptt_pkg::REG_SLOW:   slow_q   <= cfg_data;
				ptt_pkg::REG_FAST:   fast_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_q     <= pressure;
			limit_q <= sample_epoch - {23'd0, window_q};
		end
	end

	// The output register loads when a result is ready and the previous beat has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_epoch_q <= '0;
			fill_q       <= '0;
			start_q      <= 1'b0;
			acc_q        <= 1'b0;
			found_q      <= 1'b0;
			have_q       <= 1'b0;
			held_delta_q <= '0;
			held_class_q <= ptt_pkg::CLASS_STEADY;
			out_acc_q    <= 1'b0;
			out_found_q  <= 1'b0;
			out_have_q   <= 1'b0;
			out_delta_q  <= '0;
			out_class_q  <= ptt_pkg::CLASS_STEADY;
		end else begin
			start_q <= shift_en;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						found_q <= 1'b0;
						acc_q   <= ok;
						if (ok) begin
							last_epoch_q <= sample_epoch;
							if (fill_q != CW'(HISTORY_DEPTH)) begin
								fill_q <= fill_q + CW'(1);
							end
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (tok_w[HISTORY_DEPTH-1].valid) begin
						if (tok_w[HISTORY_DEPTH-1].hit) begin
							held_delta_q <= d19[17:0];
							held_class_q <= cls;
							have_q       <= 1'b1;
							found_q      <= 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_acc_q   <= acc_q;
						out_found_q <= found_q;
						out_have_q  <= have_q;
						out_delta_q <= held_delta_q;
						out_class_q <= held_class_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = out_acc_q;
	assign found_reference = out_found_q;
	assign trend_valid     = out_have_q;
	assign delta           = out_delta_q;
	assign trend_class     = out_class_q;

endmodule
